@@ design/levenshtein_edit_distance_macros.svh @@
// Assertion macros for the edit distance RTL.
`ifndef LEVENSHTEIN_EDIT_DISTANCE_MACROS_SVH
`define LEVENSHTEIN_EDIT_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LED_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define LED_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/led_pkg.sv @@
// Package with constants, types and helpers of the edit distance engine.
package led_pkg;

    localparam int MAX_LEN     = 64;
    localparam int FRAC_BITS   = 16;
    localparam int CHAR_W      = 16;
    localparam int CMD_W       = 2;
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int NORM_W      = FRAC_BITS + 1;
    localparam int CNT_W       = $clog2(NORM_W);
    localparam int IN_TDATA_W  = ((CHAR_W + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 * LEN_W + NORM_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int DIST_LSB    = 0;
    localparam int LONG_LSB    = LEN_W;
    localparam int NORM_LSB    = 2 * LEN_W;

    localparam logic [CHAR_W-1:0] UPPER_A     = CHAR_W'(16'h0041);
    localparam logic [CHAR_W-1:0] UPPER_Z     = CHAR_W'(16'h005A);
    localparam logic [CHAR_W-1:0] CASE_OFFSET = CHAR_W'(16'h0020);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND_FIRST  = 2'd0,
        CMD_APPEND_SECOND = 2'd1,
        CMD_COMPUTE       = 2'd2
    } led_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_CELL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } led_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } led_div_stat_t;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic en);
        if (en && (c >= UPPER_A) && (c <= UPPER_Z)) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

@@ design/led_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module led_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/led_div.sv @@
// Bit-serial restoring divider for the normalized distance quotient.
module led_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [led_pkg::LEN_W-1:0]   dividend,
    input  logic [led_pkg::LEN_W-1:0]   divisor,
    output led_pkg::led_div_stat_t      stat,
    output logic [led_pkg::NORM_W-1:0]  quotient
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [led_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         first_reg, first_next;
    logic [led_pkg::LEN_W-1:0]    rem_reg, rem_next;
    logic [led_pkg::LEN_W-1:0]    dvs_reg, dvs_next;
    logic [led_pkg::NORM_W-1:0]   quot_reg, quot_next;
    logic [led_pkg::LEN_W:0]      trial;
    logic [led_pkg::LEN_W:0]      diff;
    logic                         ge;

    always_comb begin
        trial = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge    = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};

        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        quot_next  = quot_reg;

        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = led_pkg::CNT_W'(led_pkg::NORM_W - 1);
            first_next = 1'b1;
            rem_next   = dividend;
            dvs_next   = divisor;
        end else if (busy_reg) begin
            first_next = 1'b0;
            rem_next   = ge ? diff[led_pkg::LEN_W-1:0] : trial[led_pkg::LEN_W-1:0];
            quot_next  = {quot_reg[led_pkg::NORM_W-2:0], ge};
            cnt_next   = cnt_reg - led_pkg::CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        quot_reg  <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

@@ design/levenshtein_edit_distance.sv @@
// Top level of the normalized Levenshtein edit distance engine.
//
//  Channel  | Ports                    | Carries
//  ---------+--------------------------+-------------------------------------------
//  s_       | s_tvalid/tready/tdata/.. | append or compute request (command in tuser)
//  m_       | m_tvalid/tready/tdata/.. | distance, longer length, Q1.16 ratio, flag
//  cfg_     | cfg_wr_en/cfg_wr_data    | case_fold register
//
// An append request leaves s_tready high for the next request. A compute request
// walks the table one cell per cycle through the cost-row RAM and the shared
// compare/min unit, with a setup state per row, then takes 17 divider steps.
// s_tready is low from compute until its result is loaded into the output register.
// Reset is synchronous, active low; the string and cost RAMs are not cleared.
module levenshtein_edit_distance (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [led_pkg::IN_TDATA_W-1:0]   s_tdata,   // [15:0] char_code
    input  logic [led_pkg::CMD_W-1:0]        s_tuser,   // [1:0] command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [led_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [6:0] edit_distance,
                                                        // [13:7] longer_length,
                                                        // [30:14] normalized_distance
    output logic                             m_tuser    // [0] truncated
);

    `include "levenshtein_edit_distance_macros.svh"

    led_pkg::led_state_t              state_reg, state_next;
    logic                             fold_reg;
    logic [led_pkg::LEN_W-1:0]        len1_reg, len1_next;
    logic [led_pkg::LEN_W-1:0]        len2_reg, len2_next;
    logic                             ovf_reg, ovf_next;
    logic [led_pkg::LEN_W-1:0]        i_reg, i_next;
    logic [led_pkg::LEN_W-1:0]        j_reg, j_next;
    logic [led_pkg::LEN_W-1:0]        diag_reg, diag_next;
    logic [led_pkg::LEN_W-1:0]        left_reg, left_next;
    logic [led_pkg::LEN_W-1:0]        dist_reg, dist_next;
    logic [led_pkg::LEN_W-1:0]        longer_reg, longer_next;
    logic [led_pkg::NORM_W-1:0]       norm_reg, norm_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [led_pkg::OUT_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                             m_tuser_reg, m_tuser_next;

    led_pkg::led_cmd_t                cmd;
    logic                             accept;
    logic [led_pkg::LEN_W-1:0]        max_len;
    logic [led_pkg::LEN_W-1:0]        i_minus1;
    logic [led_pkg::LEN_W-1:0]        j_minus1;
    logic [led_pkg::LEN_W-1:0]        above;
    logic [led_pkg::LEN_W-1:0]        cand_up;
    logic [led_pkg::LEN_W-1:0]        cand_left;
    logic [led_pkg::LEN_W-1:0]        cand_diag;
    logic [led_pkg::LEN_W-1:0]        best;
    logic [led_pkg::CHAR_W-1:0]       char_a;
    logic [led_pkg::CHAR_W-1:0]       char_b;

    logic                             s1_wr_en, s2_wr_en, s1_rd_en, s2_rd_en;
    logic [led_pkg::ADDR_W-1:0]       s1_wr_addr, s2_wr_addr, s1_rd_addr, s2_rd_addr;
    logic [led_pkg::CHAR_W-1:0]       s1_rd_data, s2_rd_data;
    logic                             cr_wr_en, cr_rd_en;
    logic [led_pkg::ADDR_W-1:0]       cr_wr_addr, cr_rd_addr;
    logic [led_pkg::LEN_W-1:0]        cr_wr_data, cr_rd_data;

    logic                             div_start;
    led_pkg::led_div_stat_t           div_stat;
    logic [led_pkg::NORM_W-1:0]       div_quot;

    led_ram #(.WIDTH(led_pkg::CHAR_W), .DEPTH(led_pkg::MAX_LEN)) u_first_ram (
        .aclk    (aclk),
        .wr_en   (s1_wr_en),
        .wr_addr (s1_wr_addr),
        .wr_data (s_tdata[led_pkg::CHAR_W-1:0]),
        .rd_en   (s1_rd_en),
        .rd_addr (s1_rd_addr),
        .rd_data (s1_rd_data)
    );

    led_ram #(.WIDTH(led_pkg::CHAR_W), .DEPTH(led_pkg::MAX_LEN)) u_second_ram (
        .aclk    (aclk),
        .wr_en   (s2_wr_en),
        .wr_addr (s2_wr_addr),
        .wr_data (s_tdata[led_pkg::CHAR_W-1:0]),
        .rd_en   (s2_rd_en),
        .rd_addr (s2_rd_addr),
        .rd_data (s2_rd_data)
    );

    // Entry k holds cost_row[k+1]; column zero is tracked in registers.
    led_ram #(.WIDTH(led_pkg::LEN_W), .DEPTH(led_pkg::MAX_LEN)) u_cost_ram (
        .aclk    (aclk),
        .wr_en   (cr_wr_en),
        .wr_addr (cr_wr_addr),
        .wr_data (cr_wr_data),
        .rd_en   (cr_rd_en),
        .rd_addr (cr_rd_addr),
        .rd_data (cr_rd_data)
    );

    led_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dist_reg),
        .divisor  (longer_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign cmd      = led_pkg::led_cmd_t'(s_tuser);
    assign s_tready = (state_reg == led_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign max_len  = led_pkg::LEN_W'(led_pkg::MAX_LEN);
    assign i_minus1 = i_reg - led_pkg::LEN_W'(1);
    assign j_minus1 = j_reg - led_pkg::LEN_W'(1);

    // Shared cell unit: fold, compare, three-way minimum.
    always_comb begin
        char_a    = led_pkg::fold_char(s1_rd_data, fold_reg);
        char_b    = led_pkg::fold_char(s2_rd_data, fold_reg);
        above     = (i_reg == led_pkg::LEN_W'(1)) ? j_reg : cr_rd_data;
        cand_up   = above + led_pkg::LEN_W'(1);
        cand_left = left_reg + led_pkg::LEN_W'(1);
        cand_diag = diag_reg + led_pkg::LEN_W'(char_a != char_b);
        best      = cand_up;
        if (cand_left < best) begin
            best = cand_left;
        end
        if (cand_diag < best) begin
            best = cand_diag;
        end
    end

    always_comb begin
        state_next    = state_reg;
        len1_next     = len1_reg;
        len2_next     = len2_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        diag_next     = diag_reg;
        left_next     = left_reg;
        dist_next     = dist_reg;
        longer_next   = longer_reg;
        norm_next     = norm_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        s1_wr_en   = 1'b0;
        s2_wr_en   = 1'b0;
        s1_wr_addr = len1_reg[led_pkg::ADDR_W-1:0];
        s2_wr_addr = len2_reg[led_pkg::ADDR_W-1:0];
        s1_rd_en   = 1'b0;
        s2_rd_en   = 1'b0;
        s1_rd_addr = i_minus1[led_pkg::ADDR_W-1:0];
        s2_rd_addr = j_reg[led_pkg::ADDR_W-1:0];
        cr_rd_en   = 1'b0;
        cr_rd_addr = j_reg[led_pkg::ADDR_W-1:0];
        cr_wr_en   = 1'b0;
        cr_wr_addr = j_minus1[led_pkg::ADDR_W-1:0];
        cr_wr_data = best;
        div_start  = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            led_pkg::ST_IDLE: begin
                if (accept) begin
                    case (cmd)
                        led_pkg::CMD_APPEND_FIRST: begin
                            if (len1_reg < max_len) begin
                                s1_wr_en  = 1'b1;
                                len1_next = len1_reg + led_pkg::LEN_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        led_pkg::CMD_APPEND_SECOND: begin
                            if (len2_reg < max_len) begin
                                s2_wr_en  = 1'b1;
                                len2_next = len2_reg + led_pkg::LEN_W'(1);
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        led_pkg::CMD_COMPUTE: begin
                            longer_next = (len1_reg > len2_reg) ? len1_reg : len2_reg;
                            if (len1_reg == '0 || len2_reg == '0) begin
                                dist_next = longer_next;
                                if (longer_next == '0) begin
                                    norm_next  = '0;
                                    state_next = led_pkg::ST_OUT;
                                end else begin
                                    state_next = led_pkg::ST_DIV_GO;
                                end
                            end else begin
                                i_next     = led_pkg::LEN_W'(1);
                                state_next = led_pkg::ST_ROW;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            led_pkg::ST_ROW: begin
                s1_rd_en   = 1'b1;
                s2_rd_en   = 1'b1;
                s2_rd_addr = '0;
                cr_rd_en   = 1'b1;
                cr_rd_addr = '0;
                j_next     = led_pkg::LEN_W'(1);
                diag_next  = i_minus1;
                left_next  = i_reg;
                state_next = led_pkg::ST_CELL;
            end
            led_pkg::ST_CELL: begin
                cr_wr_en  = 1'b1;
                left_next = best;
                diag_next = above;
                if (j_reg < len2_reg) begin
                    s2_rd_en = 1'b1;
                    cr_rd_en = 1'b1;
                    j_next   = j_reg + led_pkg::LEN_W'(1);
                end else if (i_reg < len1_reg) begin
                    i_next     = i_reg + led_pkg::LEN_W'(1);
                    state_next = led_pkg::ST_ROW;
                end else begin
                    dist_next  = best;
                    state_next = led_pkg::ST_DIV_GO;
                end
            end
            led_pkg::ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = led_pkg::ST_DIV_WAIT;
            end
            led_pkg::ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    norm_next  = div_quot;
                    state_next = led_pkg::ST_OUT;
                end
            end
            led_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = led_pkg::OUT_TDATA_W'({norm_reg, longer_reg, dist_reg});
                    m_tuser_next  = ovf_reg;
                    len1_next     = '0;
                    len2_next     = '0;
                    ovf_next      = 1'b0;
                    state_next    = led_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = led_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= led_pkg::ST_IDLE;
            fold_reg     <= 1'b0;
            len1_reg     <= '0;
            len2_reg     <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len1_reg     <= len1_next;
            len2_reg     <= len2_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                fold_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg       <= i_next;
        j_reg       <= j_next;
        diag_reg    <= diag_next;
        left_reg    <= left_next;
        dist_reg    <= dist_next;
        longer_reg  <= longer_next;
        norm_reg    <= norm_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `LED_ASSERT_IMP(a_len_bound, aclk, aresetn, 1'b1, (len1_reg <= max_len) && (len2_reg <= max_len), "string length beyond capacity")
    `LED_ASSERT_IMP(a_cell_range, aclk, aresetn, state_reg == led_pkg::ST_CELL, (j_reg != '0) && (j_reg <= len2_reg) && (i_reg != '0) && (i_reg <= len1_reg), "table cell index out of range")
    `LED_ASSERT_IMP(a_dist_le_len, aclk, aresetn, m_tvalid_reg, m_tdata_reg[led_pkg::DIST_LSB +: led_pkg::LEN_W] <= m_tdata_reg[led_pkg::LONG_LSB +: led_pkg::LEN_W], "distance exceeds longer length")
    `LED_ASSERT_IMP(a_div_idle, aclk, aresetn, state_reg == led_pkg::ST_IDLE, !div_stat.busy, "divider busy while idle")
    `LED_ASSERT_NXT(a_out_clear, aclk, aresetn, (state_reg == led_pkg::ST_OUT) && (!m_tvalid_reg || m_tready), m_tvalid_reg && (len1_reg == '0) && (len2_reg == '0) && !ovf_reg, "result load did not clear strings")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the normalized Levenshtein edit distance engine.
module tb;
    import led_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 400;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] code;
    } request_t;

    typedef struct packed {
        logic [LEN_W-1:0]  distance;
        logic [LEN_W-1:0]  longer;
        logic [NORM_W-1:0] ratio;
        logic              truncated;
    } ed_result_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic                    cfg_wr_data = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]        s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tuser;

    request_t   pending_requests [$];
    ed_result_t expected_scores [$];
    request_t   next_req;
    ed_result_t seen;
    ed_result_t want;

    logic [CHAR_W-1:0] first_str [MAX_LEN];
    logic [CHAR_W-1:0] second_str [MAX_LEN];
    int   first_len = 0;
    int   second_len = 0;
    logic overflow_pending = 1'b0;
    logic fold_en = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic long_hold_req = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int error_count = 0;
    int requests_accepted = 0;
    int results_checked = 0;
    int dropped_results = 0;

    levenshtein_edit_distance u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
        if (fold_en && c >= UPPER_A && c <= UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic int edit_cost();
        int row [MAX_LEN+1];
        int diag;
        int above;
        int best;
        int sub;
        logic [CHAR_W-1:0] a;
        for (int j = 0; j <= second_len; j++) row[j] = j;
        for (int i = 1; i <= first_len; i++) begin
            diag = row[0];
            a = lower_ascii(first_str[i-1]);
            row[0] = i;
            for (int j = 1; j <= second_len; j++) begin
                above = row[j];
                best = above + 1;
                if (row[j-1] + 1 < best) best = row[j-1] + 1;
                sub = diag + ((a == lower_ascii(second_str[j-1])) ? 0 : 1);
                if (sub < best) best = sub;
                row[j] = best;
                diag = above;
            end
        end
        return row[second_len];
    endfunction

    function automatic void apply_request(input logic [CMD_W-1:0] cmd,
                                          input logic [CHAR_W-1:0] code);
        int longer_len;
        int edit_count;
        longint ratio;
        ed_result_t r;
        case (cmd)
            CMD_APPEND_FIRST: begin
                if (first_len < MAX_LEN) begin
                    first_str[first_len] = code;
                    first_len++;
                end else begin
                    overflow_pending = 1'b1;
                end
            end
            CMD_APPEND_SECOND: begin
                if (second_len < MAX_LEN) begin
                    second_str[second_len] = code;
                    second_len++;
                end else begin
                    overflow_pending = 1'b1;
                end
            end
            CMD_COMPUTE: begin
                longer_len = (first_len > second_len) ? first_len : second_len;
                if (first_len == 0 || second_len == 0) begin
                    edit_count = longer_len;
                    ratio = (longer_len == 0) ? 0 : (longint'(1) << FRAC_BITS);
                end else begin
                    edit_count = edit_cost();
                    ratio = (longint'(edit_count) << FRAC_BITS) / longer_len;
                end
                r.distance = LEN_W'(edit_count);
                r.longer = LEN_W'(longer_len);
                r.ratio = NORM_W'(ratio);
                r.truncated = overflow_pending;
                expected_scores.push_back(r);
                if (overflow_pending) dropped_results++;
                first_len = 0;
                second_len = 0;
                overflow_pending = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void queue_request(input logic [CMD_W-1:0] cmd,
                                          input logic [CHAR_W-1:0] code);
        request_t q;
        q.cmd = cmd;
        q.code = code;
        pending_requests.push_back(q);
    endfunction

    function automatic logic [CHAR_W-1:0] near_char();
        case ($urandom_range(9))
            0: return 16'h0040;
            1: return 16'h0041;
            2: return 16'h0042;
            3: return 16'h005A;
            4: return 16'h005B;
            5: return 16'h0060;
            6: return 16'h0061;
            7: return 16'h0062;
            8: return 16'h007A;
            default: return 16'h007B;
        endcase
    endfunction

    function automatic int pick_length();
        int size_pick;
        size_pick = $urandom_range(99);
        if (size_pick < 80) return $urandom_range(10);
        if (size_pick < 97) return $urandom_range(40, 11);
        return $urandom_range(70, 60);
    endfunction

    // Queue appends for two strings in random interleave, with occasional unused commands, then one compute.
    function automatic int queue_string_pair();
        logic [CHAR_W-1:0] a [$];
        logic [CHAR_W-1:0] b [$];
        logic [CHAR_W-1:0] c;
        int len_a;
        int len_b;
        int style;
        int count;
        style = $urandom_range(3);
        len_a = pick_length();
        for (int i = 0; i < len_a; i++) begin
            a.push_back((style == 0) ? CHAR_W'($urandom) : near_char());
        end
        case (style)
            0, 1: begin
                len_b = pick_length();
                for (int i = 0; i < len_b; i++) begin
                    b.push_back((style == 0) ? CHAR_W'($urandom) : near_char());
                end
            end
            2: begin
                b = a;
                repeat ($urandom_range(3)) begin
                    case ($urandom_range(2))
                        0: if (b.size() != 0) b[$urandom_range(b.size() - 1)] = near_char();
                        1: b.insert($urandom_range(b.size()), near_char());
                        default: if (b.size() != 0) b.delete($urandom_range(b.size() - 1));
                    endcase
                end
            end
            default: begin
                foreach (a[i]) begin
                    c = a[i];
                    if (((c >= UPPER_A && c <= UPPER_Z) ||
                         (c >= UPPER_A + CASE_OFFSET && c <= UPPER_Z + CASE_OFFSET)) &&
                        $urandom_range(1) == 1) begin
                        c = c ^ CASE_OFFSET;
                    end
                    b.push_back(c);
                end
            end
        endcase
        count = 0;
        while (a.size() != 0 || b.size() != 0) begin
            if ($urandom_range(99) < 3) queue_request(CMD_UNUSED, CHAR_W'($urandom));
            if (b.size() == 0 || (a.size() != 0 && $urandom_range(1) == 1)) begin
                queue_request(CMD_APPEND_FIRST, a.pop_front());
            end else begin
                queue_request(CMD_APPEND_SECOND, b.pop_front());
            end
            count++;
        end
        queue_request(CMD_COMPUTE, CHAR_W'($urandom));
        return count + 1;
    endfunction

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_scores.size() != 0);
    endtask

    task automatic write_fold(input logic value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        fold_en = value;
    endtask

    task automatic run_phase(input logic fold, input int idle_pct, input int stall_pct,
                             input logic hold);
        int added;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_fold(fold);
        @(negedge aclk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if (hold) begin
            long_hold_req = 1'b1;
            @(negedge aclk);
            long_hold_req = 1'b0;
        end
        added = 0;
        while (added < PHASE_ITEMS / 2) added += queue_string_pair();
        wait_drained();
        while (added < PHASE_ITEMS) added += queue_string_pair();
        wait_drained();
    endtask

    // Request driver; predict each request as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser, s_tdata[CHAR_W-1:0]);
                requests_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= IN_TDATA_W'(next_req.code);
                    s_tuser <= next_req.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (long_hold_req) begin
            hold_left <= LONG_HOLD;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.distance = m_tdata[DIST_LSB +: LEN_W];
                seen.longer = m_tdata[LONG_LSB +: LEN_W];
                seen.ratio = m_tdata[NORM_LSB +: NORM_W];
                seen.truncated = m_tuser;
                if (expected_scores.size() == 0) begin
                    if (error_count < 10) begin
                        $display("unexpected result: dist=%0d len=%0d norm=%0d trunc=%0d",
                                 seen.distance, seen.longer, seen.ratio, seen.truncated);
                    end
                    error_count++;
                end else begin
                    want = expected_scores.pop_front();
                    results_checked++;
                    if (seen.distance !== want.distance || seen.longer !== want.longer ||
                        seen.ratio !== want.ratio || seen.truncated !== want.truncated) begin
                        if (error_count < 10) begin
                            $display("mismatch: exp dist=%0d len=%0d norm=%0d trunc=%0d",
                                     want.distance, want.longer, want.ratio, want.truncated);
                            $display("          got dist=%0d len=%0d norm=%0d trunc=%0d",
                                     seen.distance, seen.longer, seen.ratio, seen.truncated);
                        end
                        error_count++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        write_fold(1'b1);
        @(negedge aclk);
        queue_request(CMD_COMPUTE, 16'h0000);
        queue_request(CMD_APPEND_FIRST, 16'h0041);
        queue_request(CMD_APPEND_SECOND, 16'h0061);
        queue_request(CMD_COMPUTE, 16'hFFFF);
        queue_request(CMD_APPEND_FIRST, 16'hFFFF);
        queue_request(CMD_COMPUTE, 16'h1234);
        queue_request(CMD_APPEND_SECOND, 16'h0000);
        queue_request(CMD_APPEND_SECOND, 16'h005A);
        queue_request(CMD_APPEND_FIRST, 16'h007A);
        queue_request(CMD_APPEND_FIRST, 16'h005B);
        queue_request(CMD_COMPUTE, 16'h0000);
        queue_request(CMD_UNUSED, 16'hFFFF);
        queue_request(CMD_APPEND_FIRST, 16'h0040);
        queue_request(CMD_APPEND_SECOND, 16'h0060);
        queue_request(CMD_COMPUTE, 16'h8001);
        queue_request(CMD_APPEND_FIRST, 16'h0041);
        queue_request(CMD_APPEND_FIRST, 16'h0062);
        queue_request(CMD_APPEND_SECOND, 16'h0061);
        queue_request(CMD_APPEND_SECOND, 16'h0042);
        queue_request(CMD_COMPUTE, 16'h7FFE);
        // overfill both strings with disjoint code units
        for (int i = 0; i < MAX_LEN + 1; i++) begin
            queue_request(CMD_APPEND_FIRST, {1'b1, 15'($urandom)});
        end
        for (int i = 0; i < MAX_LEN + 2; i++) begin
            queue_request(CMD_APPEND_SECOND, {1'b0, 15'($urandom)});
        end
        queue_request(CMD_COMPUTE, 16'h0000);
        wait_drained();

        run_phase(1'b0, 0, 0, 1'b0);
        run_phase(1'b1, 49, 0, 1'b0);
        run_phase(1'b0, 0, 49, 1'b1);
        run_phase(1'b1, 7, 7, 1'b0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("checked %0d distance results from %0d requests, %0d with dropped units",
                 results_checked, requests_accepted, dropped_results);
        $display("covered case folding on and off, sender and receiver idling, long output hold");
        if (expected_scores.size() != 0) begin
            $display("%0d distance results never arrived", expected_scores.size());
        end
        if (error_count == 0 && expected_scores.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
